>>> rtl/core/pfs_pkg.sv
package pfs_pkg;

    localparam int MaxWaypoints = 256;
    localparam int WpAddrW = $clog2(MaxWaypoints);
    localparam int PtrW = $clog2(MaxWaypoints + 1);

    typedef enum logic [2:0] {
        KIND_INIT   = 3'd0,
        KIND_LOAD   = 3'd1,
        KIND_WIND   = 3'd2,
        KIND_START  = 3'd3,
        KIND_TICK   = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        REG_SIGHT  = 3'd0,
        REG_PATH   = 3'd1,
        REG_PGAIN  = 3'd2,
        REG_WGAIN  = 3'd3,
        REG_WEN    = 3'd4,
        REG_LEN    = 3'd5
    } reg_index_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RD,
        ST_RDW,
        ST_DX,
        ST_DY,
        ST_SQX,
        ST_SQY,
        ST_CMP,
        ST_PATH,
        ST_FUT,
        ST_NORM,
        ST_LSQX,
        ST_LSQY,
        ST_SQRT,
        ST_DIVX,
        ST_DIVY,
        ST_GAIN,
        ST_GAINY,
        ST_WINDX,
        ST_WINDY,
        ST_SUM,
        ST_POS,
        ST_OUT
    } state_t;

    function automatic logic [31:0] sat32(input logic signed [37:0] v);
        if (v > 38'sd2147483647)
            return 32'h7fffffff;
        else if (v < -38'sd2147483648)
            return 32'h80000000;
        else
            return v[31:0];
    endfunction

endpackage

>>> rtl/core/pfs_mul.sv
module pfs_mul (
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] p
);

    logic [63:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= {32'd0, a} * {32'd0, b};
    end

    assign p = p_reg;

endmodule

>>> rtl/core/pfs_sqrt_div.sv
module pfs_sqrt_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start_sqrt,
    input  logic        start_div,
    input  logic [63:0] radicand,
    input  logic [40:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [40:0] result
);

    logic        busy_reg, busy_next;
    logic        is_div_reg, is_div_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] bit_reg, bit_next;
    logic [40:0] q_reg, q_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [41:0] trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_div_reg <= is_div_next;
        rem_reg    <= rem_next;
        acc_reg    <= acc_next;
        bit_reg    <= bit_next;
        q_reg      <= q_next;
        dvs_reg    <= dvs_next;
    end

    always_comb
    begin
        busy_next   = busy_reg;
        is_div_next = is_div_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        acc_next    = acc_reg;
        bit_next    = bit_reg;
        q_next      = q_reg;
        dvs_next    = dvs_reg;
        done        = 1'b0;
        trial       = {rem_reg[40:0], q_reg[40]} - {10'd0, dvs_reg};
        if (start_sqrt)
        begin
            busy_next   = 1'b1;
            is_div_next = 1'b0;
            cnt_next    = 6'd32;
            rem_next    = radicand;
            acc_next    = '0;
            bit_next    = 64'h4000000000000000;
        end
        else if (start_div)
        begin
            busy_next   = 1'b1;
            is_div_next = 1'b1;
            cnt_next    = 6'd41;
            rem_next    = '0;
            q_next      = dividend;
            dvs_next    = divisor;
        end
        else if (busy_reg)
        begin
            if (is_div_reg)
            begin
                if (!trial[41])
                begin
                    rem_next = {23'd0, trial[40:0]};
                    q_next   = {q_reg[39:0], 1'b1};
                end
                else
                begin
                    rem_next = {22'd0, rem_reg[40:0], q_reg[40]};
                    q_next   = {q_reg[39:0], 1'b0};
                end
            end
            else
            begin
                if (rem_reg >= acc_reg + bit_reg)
                begin
                    rem_next = rem_reg - (acc_reg + bit_reg);
                    acc_next = (acc_reg >> 1) + bit_reg;
                end
                else
                    acc_next = acc_reg >> 1;
                bit_next = bit_reg >> 2;
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    assign result = is_div_reg ? q_next : acc_next[40:0];

endmodule

>>> rtl/core/path_following_steer_step.sv
// init, load, wind and unknown kinds give the result in the cycle after acceptance
// start: checks waypoints from slot 0 until one is within sight or the list ends
// tick: while following, skips waypoints within sight, then does the end or path check,
// and when steering also normalizes, takes a 32-step square root and two 41-step divides
// one transaction at a time: s_tready is low from acceptance until the result is taken,
// the next transaction can be accepted in the cycle after; rst_n async clears state, not waypoints
module path_following_steer_step (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,   // waypoint_index, x, y, dx, dy
    input  logic [2:0]   s_tuser,   // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,   // pos_x, pos_y, vel_x, vel_y, target_slot
    output logic         m_tuser,   // following
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int AW = pfs_pkg::WpAddrW;
    localparam int PW = pfs_pkg::PtrW;

    pfs_pkg::state_t st_reg, st_next;

    logic [30:0] sight_reg, path_reg;
    logic [20:0] pgain_reg, wgain_reg;
    logic        wen_reg;
    logic [8:0]  len_reg;

    logic signed [31:0] px_reg, py_reg, vx_reg, vy_reg, sx_reg, sy_reg, wx_reg, wy_reg;
    logic signed [31:0] px_next, py_next, vx_next, vy_next, sx_next, sy_next;
    logic [PW-1:0] tp_reg, tp_next;
    logic          ff_reg, ff_next;
    logic          start_reg, start_next;

    logic [63:0] wmem [0:pfs_pkg::MaxWaypoints-1];
    logic [63:0] wrd_reg;

    logic [63:0] ax_reg, ay_reg, ax_next, ay_next;
    logic        nx_reg, ny_reg, nx_next, ny_next;
    logic [64:0] acc_reg, acc_next;
    logic [31:0] len_val_reg, len_val_next;
    logic signed [37:0] tvx_reg, tvy_reg, tvx_next, tvy_next;
    logic [63:0] sight_sq_reg, sight_sq_next, path_sq_reg, path_sq_next;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic        sd_sqrt, sd_div, sd_done;
    logic [40:0] sd_dividend, sd_res;
    logic [PW-1:0] n_eff;
    logic [2:0]  kind;
    logic signed [32:0] fut_dx, fut_dy;
    logic [63:0] gmul;
    logic signed [37:0] gterm;
    logic        accept;

    pfs_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

    pfs_sqrt_div u_sd (
        .clk(clk), .rst_n(rst_n), .start_sqrt(sd_sqrt), .start_div(sd_div),
        .radicand(acc_reg[63:0]), .dividend(sd_dividend), .divisor(len_val_reg),
        .done(sd_done), .result(sd_res)
    );

    assign s_tready  = (st_reg == pfs_pkg::ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign kind      = s_tuser;
    assign n_eff     = (len_reg > 9'(pfs_pkg::MaxWaypoints)) ?
                       PW'(pfs_pkg::MaxWaypoints) : PW'(len_reg);
    assign gmul      = (mul_p + 64'd32768) >> 16;
    assign gterm     = signed'(gmul[37:0]);
    assign m_tvalid  = (st_reg == pfs_pkg::ST_OUT);
    assign m_tdata   = {7'd0, tp_reg, vy_reg, vx_reg, py_reg, px_reg};
    assign m_tuser   = ff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sight_reg <= 31'd3276800;
            path_reg  <= 31'd655360;
            pgain_reg <= 21'd65536;
            wgain_reg <= 21'd65536;
            wen_reg   <= 1'b0;
            len_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                pfs_pkg::REG_SIGHT: sight_reg <= cfg_data[30:0];
                pfs_pkg::REG_PATH:  path_reg  <= cfg_data[30:0];
                pfs_pkg::REG_PGAIN: pgain_reg <= cfg_data[20:0];
                pfs_pkg::REG_WGAIN: wgain_reg <= cfg_data[20:0];
                pfs_pkg::REG_WEN:   wen_reg   <= cfg_data[0];
                pfs_pkg::REG_LEN:   len_reg   <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && kind == pfs_pkg::KIND_LOAD)
            wmem[s_tdata[AW-1:0]] <= {s_tdata[71:40], s_tdata[39:8]};
        wrd_reg <= wmem[tp_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= pfs_pkg::ST_IDLE;
            px_reg <= '0; py_reg <= '0; vx_reg <= '0; vy_reg <= '0;
            sx_reg <= '0; sy_reg <= '0; wx_reg <= '0; wy_reg <= '0;
            tp_reg <= '0; ff_reg <= 1'b0; start_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            px_reg <= px_next; py_reg <= py_next;
            vx_reg <= vx_next; vy_reg <= vy_next;
            sx_reg <= sx_next; sy_reg <= sy_next;
            tp_reg <= tp_next; ff_reg <= ff_next; start_reg <= start_next;
            if (accept && kind == pfs_pkg::KIND_WIND)
            begin
                wx_reg <= s_tdata[39:8];
                wy_reg <= s_tdata[71:40];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg <= ax_next; ay_reg <= ay_next;
        nx_reg <= nx_next; ny_reg <= ny_next;
        acc_reg <= acc_next; len_val_reg <= len_val_next;
        tvx_reg <= tvx_next; tvy_reg <= tvy_next;
        sight_sq_reg <= sight_sq_next; path_sq_reg <= path_sq_next;
    end

    always_comb
    begin
        st_next = st_reg;
        px_next = px_reg; py_next = py_reg; vx_next = vx_reg; vy_next = vy_reg;
        sx_next = sx_reg; sy_next = sy_reg; tp_next = tp_reg; ff_next = ff_reg;
        start_next = start_reg;
        ax_next = ax_reg; ay_next = ay_reg; nx_next = nx_reg; ny_next = ny_reg;
        acc_next = acc_reg; len_val_next = len_val_reg;
        tvx_next = tvx_reg; tvy_next = tvy_reg;
        sight_sq_next = sight_sq_reg; path_sq_next = path_sq_reg;
        mul_a = ax_reg[31:0]; mul_b = ax_reg[31:0];
        sd_sqrt = 1'b0; sd_div = 1'b0;
        sd_dividend = {ax_reg[24:0], 16'd0} + {10'd0, len_val_reg[31:1]};
        fut_dx = '0; fut_dy = '0;
        case (st_reg)
            pfs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    st_next = pfs_pkg::ST_OUT;
                    case (kind)
                        pfs_pkg::KIND_INIT:
                        begin
                            px_next = s_tdata[39:8];   py_next = s_tdata[71:40];
                            vx_next = s_tdata[103:72]; vy_next = s_tdata[135:104];
                        end
                        pfs_pkg::KIND_START:
                        begin
                            ff_next = 1'b1; tp_next = '0; start_next = 1'b1;
                            st_next = pfs_pkg::ST_RD;
                        end
                        pfs_pkg::KIND_TICK:
                        begin
                            start_next = 1'b0;
                            tvx_next = 38'(vx_reg); tvy_next = 38'(vy_reg);
                            if (ff_reg)
                            begin
                                if (tp_reg >= n_eff)
                                begin
                                    ff_next = 1'b0;
                                    st_next = pfs_pkg::ST_GAIN;
                                end
                                else
                                    st_next = pfs_pkg::ST_RD;
                            end
                            else
                                st_next = pfs_pkg::ST_GAIN;
                        end
                        default: ;
                    endcase
                end
            end
            pfs_pkg::ST_RD:
            begin
                mul_a = {1'b0, sight_reg}; mul_b = {1'b0, sight_reg};
                if (tp_reg >= n_eff)
                begin
                    if (!start_reg) ff_next = 1'b0;
                    st_next = start_reg ? pfs_pkg::ST_OUT : pfs_pkg::ST_GAIN;
                end
                else
                    st_next = pfs_pkg::ST_RDW;
            end
            pfs_pkg::ST_RDW:
            begin
                mul_a = {1'b0, path_reg}; mul_b = {1'b0, path_reg};
                sight_sq_next = mul_p;
                st_next = pfs_pkg::ST_DX;
            end
            pfs_pkg::ST_DX:
            begin
                path_sq_next = mul_p;
                fut_dx = 33'(signed'(wrd_reg[31:0])) - 33'(px_reg);
                fut_dy = 33'(signed'(wrd_reg[63:32])) - 33'(py_reg);
                ax_next = fut_dx[32] ? 64'(-fut_dx) : 64'(fut_dx);
                ay_next = fut_dy[32] ? 64'(-fut_dy) : 64'(fut_dy);
                if (ax_next > 64'hffffffff) ax_next = 64'hffffffff;
                if (ay_next > 64'hffffffff) ay_next = 64'hffffffff;
                st_next = pfs_pkg::ST_DY;
            end
            pfs_pkg::ST_DY:
            begin
                mul_a = ax_reg[31:0]; mul_b = ax_reg[31:0];
                st_next = pfs_pkg::ST_SQX;
            end
            pfs_pkg::ST_SQX:
            begin
                mul_a = ay_reg[31:0]; mul_b = ay_reg[31:0];
                acc_next = {1'b0, mul_p};
                st_next = pfs_pkg::ST_SQY;
            end
            pfs_pkg::ST_SQY:
            begin
                acc_next = acc_reg + {1'b0, mul_p};
                if (acc_next[64]) acc_next = {1'b0, 64'hffffffffffffffff};
                st_next = pfs_pkg::ST_CMP;
            end
            pfs_pkg::ST_CMP:
            begin
                if (start_reg)
                begin
                    if (acc_reg[63:0] < sight_sq_reg) st_next = pfs_pkg::ST_OUT;
                    else
                    begin
                        tp_next = tp_reg + PW'(1);
                        st_next = pfs_pkg::ST_RD;
                    end
                end
                else if (acc_reg[63:0] < sight_sq_reg)
                begin
                    tp_next = tp_reg + PW'(1);
                    st_next = pfs_pkg::ST_RD;
                end
                else
                    st_next = pfs_pkg::ST_PATH;
            end
            pfs_pkg::ST_PATH:
            begin
                if (acc_reg[63:0] > path_sq_reg) st_next = pfs_pkg::ST_FUT;
                else
                begin
                    sx_next = '0; sy_next = '0;
                    st_next = pfs_pkg::ST_GAIN;
                end
            end
            pfs_pkg::ST_FUT:
            begin
                fut_dx = 33'(signed'(wrd_reg[31:0])) -
                         33'(signed'(pfs_pkg::sat32(38'(px_reg) + 38'(vx_reg))));
                fut_dy = 33'(signed'(wrd_reg[63:32])) -
                         33'(signed'(pfs_pkg::sat32(38'(py_reg) + 38'(vy_reg))));
                nx_next = fut_dx[32]; ny_next = fut_dy[32];
                ax_next = fut_dx[32] ? 64'(-fut_dx) : 64'(fut_dx);
                ay_next = fut_dy[32] ? 64'(-fut_dy) : 64'(fut_dy);
                if (ax_next == 0 && ay_next == 0)
                begin
                    sx_next = '0; sy_next = '0;
                    st_next = pfs_pkg::ST_GAIN;
                end
                else
                    st_next = pfs_pkg::ST_NORM;
            end
            pfs_pkg::ST_NORM:
            begin
                if ((ax_reg | ay_reg) >= 64'h1000000)
                begin
                    ax_next = ax_reg >> 1; ay_next = ay_reg >> 1;
                end
                else if ((ax_reg | ay_reg) < 64'h800000)
                begin
                    ax_next = ax_reg << 1; ay_next = ay_reg << 1;
                end
                else
                    st_next = pfs_pkg::ST_LSQX;
                mul_a = ax_reg[31:0]; mul_b = ax_reg[31:0];
            end
            pfs_pkg::ST_LSQX:
            begin
                mul_a = ay_reg[31:0]; mul_b = ay_reg[31:0];
                acc_next = {1'b0, mul_p};
                st_next = pfs_pkg::ST_LSQY;
            end
            pfs_pkg::ST_LSQY:
            begin
                acc_next = acc_reg + {1'b0, mul_p};
                st_next = pfs_pkg::ST_SQRT;
            end
            pfs_pkg::ST_SQRT:
            begin
                if (!start_reg && acc_reg[64:63] != 2'b11)
                begin
                    sd_sqrt = 1'b1;
                    acc_next = {2'b11, acc_reg[62:0]};
                end
                else if (sd_done)
                begin
                    len_val_next = sd_res[31:0];
                    start_next = 1'b1;
                    st_next = pfs_pkg::ST_DIVX;
                end
            end
            pfs_pkg::ST_DIVX:
            begin
                if (start_reg)
                begin
                    sd_div = 1'b1; start_next = 1'b0;
                end
                else if (sd_done)
                begin
                    sx_next = nx_reg ? -signed'(sd_res[31:0]) : signed'(sd_res[31:0]);
                    ax_next = ay_reg; start_next = 1'b1;
                    st_next = pfs_pkg::ST_DIVY;
                end
            end
            pfs_pkg::ST_DIVY:
            begin
                if (start_reg)
                begin
                    sd_div = 1'b1; start_next = 1'b0;
                end
                else if (sd_done)
                begin
                    sy_next = ny_reg ? -signed'(sd_res[31:0]) : signed'(sd_res[31:0]);
                    st_next = pfs_pkg::ST_GAIN;
                end
            end
            pfs_pkg::ST_GAIN:
            begin
                // gain products through the shared multiplier, one per cycle
                mul_a = sx_reg[31] ? -sx_reg : sx_reg; mul_b = {11'd0, pgain_reg};
                st_next = pfs_pkg::ST_GAINY;
            end
            pfs_pkg::ST_GAINY:
            begin
                if (ff_reg)
                    tvx_next = sx_reg[31] ? tvx_reg - gterm : tvx_reg + gterm;
                mul_a = sy_reg[31] ? -sy_reg : sy_reg; mul_b = {11'd0, pgain_reg};
                st_next = pfs_pkg::ST_WINDX;
            end
            pfs_pkg::ST_WINDX:
            begin
                if (ff_reg)
                    tvy_next = sy_reg[31] ? tvy_reg - gterm : tvy_reg + gterm;
                mul_a = wx_reg[31] ? -wx_reg : wx_reg; mul_b = {11'd0, wgain_reg};
                st_next = pfs_pkg::ST_WINDY;
            end
            pfs_pkg::ST_WINDY:
            begin
                if (wen_reg)
                    tvx_next = wx_reg[31] ? tvx_reg - gterm : tvx_reg + gterm;
                mul_a = wy_reg[31] ? -wy_reg : wy_reg; mul_b = {11'd0, wgain_reg};
                st_next = pfs_pkg::ST_SUM;
            end
            pfs_pkg::ST_SUM:
            begin
                if (wen_reg)
                    tvy_next = wy_reg[31] ? tvy_reg - gterm : tvy_reg + gterm;
                st_next = pfs_pkg::ST_POS;
            end
            pfs_pkg::ST_POS:
            begin
                vx_next = pfs_pkg::sat32(tvx_reg);
                vy_next = pfs_pkg::sat32(tvy_reg);
                px_next = pfs_pkg::sat32(38'(px_reg) + 38'(signed'(vx_next)));
                py_next = pfs_pkg::sat32(38'(py_reg) + 38'(signed'(vy_next)));
                st_next = pfs_pkg::ST_OUT;
            end
            pfs_pkg::ST_OUT:
            begin
                start_next = 1'b0;
                if (m_tready) st_next = pfs_pkg::ST_IDLE;
            end
            default: st_next = pfs_pkg::ST_IDLE;
        endcase
    end

endmodule
